>>> rtl/core/spi_pkg.sv
// Shared widths, field offsets and sideband type for the segment pair intersection block.
package spi_pkg;

  // Coordinate, difference, product and magnitude widths
  localparam int CW  = 32;          // Q16.16 coordinate
  localparam int MW  = CW + 1;      // coordinate difference
  localparam int PW  = 2 * MW;      // product of two differences
  localparam int SW  = PW + 1;      // difference of two products
  localparam int DW  = PW;          // magnitude of a product difference
  localparam int HW  = 33;          // split width for wide multiplies
  localparam int TW  = 16;          // tolerance register
  localparam int T2W = 2 * TW;      // tolerance squared
  localparam int NW  = 98;          // dividend and remainder width
  localparam int QW  = 33;          // quotient bits kept before clipping
  localparam int FB  = 16;          // fraction bits of the line parameters
  localparam int CSW = 49;          // offset magnitude that can still pass the overlap test
  localparam int CLW = 25;          // low part of the offset
  localparam int CHW = CSW - CLW;   // high part of the offset

  // Division lanes
  localparam int NLANE = 4;
  localparam int LN_PA = 0;
  localparam int LN_PB = 1;
  localparam int LN_CX = 2;
  localparam int LN_CY = 3;

  // Input item layout
  localparam int IN_W  = 8 * CW;
  localparam int I_ASX = 0;
  localparam int I_ASY = CW;
  localparam int I_AEX = 2 * CW;
  localparam int I_AEY = 3 * CW;
  localparam int I_BSX = 4 * CW;
  localparam int I_BSY = 5 * CW;
  localparam int I_BEX = 6 * CW;
  localparam int I_BEY = 7 * CW;

  // Result item layout
  localparam int O_COLIN = 0;
  localparam int O_OVER  = 1;
  localparam int O_CX    = 2;
  localparam int O_CY    = O_CX + CW;
  localparam int O_PA    = O_CY + CW;
  localparam int O_PB    = O_PA + CW;
  localparam int O_SAT   = O_PB + CW;
  localparam int OUT_W   = ((O_SAT + 1 + 7) / 8) * 8;

  // Data that rides along the divider
  typedef struct packed {
    logic                 colin;
    logic                 over;
    logic [NLANE-1:0]     neg;
    logic signed [CW-1:0] asx;
    logic signed [CW-1:0] asy;
  } side_t;

endpackage

>>> rtl/core/spi_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing one divisor.
module spi_div (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [spi_pkg::NLANE-1:0][spi_pkg::NW-1:0] in_num,
  input  logic [spi_pkg::DW-1:0]                  in_den,
  input  spi_pkg::side_t                          in_side,
  output logic                                    out_valid,
  output logic [spi_pkg::NLANE-1:0][spi_pkg::QW-1:0] out_quo,
  output logic [spi_pkg::NLANE-1:0]               out_ovf,
  output spi_pkg::side_t                          out_side
);
  import spi_pkg::*;

  localparam int NST = QW + 1;

  logic [NST-1:0]                vld;
  logic [NLANE-1:0][NW-1:0]      rem  [QW];
  logic [DW-1:0]                 den  [QW];
  logic [NLANE-1:0][QW-1:0]      quo  [NST];
  logic [NLANE-1:0]              ovf  [NST];
  side_t                         side [NST];

  // Entry stage: flag quotients that do not fit in QW bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= in_den;
      side[0] <= in_side;
      for (int l = 0; l < NLANE; l++) begin
        rem[0][l] <= in_num[l];
        quo[0][l] <= '0;
        ovf[0][l] <= {1'b0, in_num[l]} >= {in_den, {QW{1'b0}}};
      end
    end
  end

  // One trial subtract per stage, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [NLANE-1:0][NW:0] diff;

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      assign diff[l] = {1'b0, rem[k-1][l]} - ((NW + 1)'(den[k-1]) << B);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
        ovf[k]  <= ovf[k-1];
        for (int l = 0; l < NLANE; l++) begin
          quo[k][l] <= quo[k-1][l] | ({{(QW - 1){1'b0}}, ~diff[l][NW]} << B);
        end
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          den[k] <= den[k-1];
          for (int l = 0; l < NLANE; l++) begin
            rem[k][l] <= diff[l][NW] ? rem[k-1][l] : diff[l][NW-1:0];
          end
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_ovf   = ovf[QW];
  assign out_side  = side[QW];

endmodule

>>> rtl/core/segment_pair_intersection.sv
// Segment pair intersection: top level with product, magnitude and clipping stages.
//
// Takes one pair of Q16.16 segments per item and returns one result per item. The block
// accepts a new item every cycle while the output buffer has room and returns results in
// order: the front stages form the direction products, determinant, numerators and the
// squared overlap terms, the pipelined divider runs a range check and then one quotient
// bit per stage, four quotients side by side, a register holds the clipped and packed
// result, and the output register follows. A two-entry output buffer keeps the input
// open while one finished result waits; the input closes only when both entries are full.
// The tolerance register is written with cfg_wr_en and takes effect for items accepted
// after the write; write it only while no item is in flight.
module segment_pair_intersection (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [spi_pkg::TW-1:0]      cfg_wr_data,    // tolerance
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [spi_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // colinear, overlapped, cross_x, cross_y, param_a, param_b, saturated, zero pad
  output logic [spi_pkg::OUT_W-1:0]   m_axis_tdata
);
  import spi_pkg::*;

  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [QW-1:0] Q_HALF  = QW'(1) << (CW - 1);
  localparam logic signed [QW+1:0] PT_MAX = $signed({4'b0000, {(CW - 1){1'b1}}});
  localparam logic signed [QW+1:0] PT_MIN = $signed({4'b1111, {(CW - 1){1'b0}}});

  logic [TW-1:0] tolerance;
  logic          en;

  // Input fields
  logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;

  // Stage 1: differences
  logic                 s1_vld;
  logic signed [MW-1:0] s1_m0, s1_m1, s1_m2, s1_m3, s1_wx, s1_wy;
  logic signed [CW-1:0] s1_asx, s1_asy;

  // Stage 2: products
  logic                 s2_vld;
  logic signed [PW-1:0] s2_p03, s2_p12, s2_p0y, s2_px2, s2_p3x, s2_p1y, s2_p11, s2_p33;
  logic [T2W-1:0]       s2_tol2;
  logic [MW-1:0]        s2_m1a, s2_m3a;
  logic                 s2_m1n, s2_m3n;
  logic signed [CW-1:0] s2_asx, s2_asy;
  logic [MW-1:0]        m1_neg, m3_neg;

  // Stage 3: determinant and numerators
  logic                 s3_vld;
  logic signed [SW-1:0] s3_det, s3_nt, s3_nu;
  logic [DW-1:0]        s3_len2;
  logic [T2W-1:0]       s3_tol2;
  logic [MW-1:0]        s3_m1a, s3_m3a;
  logic                 s3_m1n, s3_m3n;
  logic signed [CW-1:0] s3_asx, s3_asy;
  logic signed [SW-1:0] det_neg, nt_neg, nu_neg;

  // Stage 4: magnitudes and tolerance products
  logic                 s4_vld;
  logic [DW-1:0]        s4_dabs, s4_ntabs, s4_nuabs;
  logic                 s4_dn, s4_ntn, s4_nun;
  logic [HW+T2W-1:0]    s4_rlo, s4_rhi;
  logic [MW-1:0]        s4_m1a, s4_m3a;
  logic                 s4_m1n, s4_m3n;
  logic signed [CW-1:0] s4_asx, s4_asy;

  // Stage 5: partial products
  logic                 s5_vld;
  logic                 s5_colin, s5_csmall;
  logic [HW+MW-1:0]     s5_xlo, s5_xhi, s5_ylo, s5_yhi;
  logic [2*CLW-1:0]     s5_cll;
  logic [CLW+CHW-1:0]   s5_clh;
  logic [2*CHW-1:0]     s5_chh;
  logic [NW-1:0]        s5_rhs;
  logic [DW-1:0]        s5_dabs, s5_ntabs, s5_nuabs;
  logic [NLANE-1:0]     s5_neg;
  logic signed [CW-1:0] s5_asx, s5_asy;

  // Stage 6: full dividends and squared terms
  logic                 s6_vld;
  logic                 s6_colin, s6_csmall;
  logic [NW-1:0]        s6_nx, s6_ny, s6_c2, s6_rhs;
  logic [DW-1:0]        s6_dabs, s6_ntabs, s6_nuabs;
  logic [NLANE-1:0]     s6_neg;
  logic signed [CW-1:0] s6_asx, s6_asy;

  // Divider
  logic [NLANE-1:0][NW-1:0] div_num;
  side_t                    div_side;
  logic                     dv_vld;
  logic [NLANE-1:0][QW-1:0] dv_quo;
  logic [NLANE-1:0]         dv_ovf;
  side_t                    dv_side;

  // Clipping and packing
  logic [CW:0]          pa_r, pb_r, cx_r, cy_r;
  logic [OUT_W-1:0]     res_next;
  logic                 res_vld;
  logic [OUT_W-1:0]     res_data;

  // Output buffer
  logic                 out_vld, skid_vld, push, pop;
  logic [OUT_W-1:0]     out_data, skid_data;

  // Clip a line parameter quotient; result is {saturated, value}
  function automatic logic [CW:0] clip_par(input logic neg, input logic ovf,
                                           input logic [QW-1:0] q);
    logic [CW-1:0] nq;
    logic [CW:0]   r;
    nq = ~q[CW-1:0] + CW'(1);
    priority if (ovf) begin
      r = neg ? {1'b1, SAT_MIN} : {1'b1, SAT_MAX};
    end else if (neg) begin
      r = (q > Q_HALF) ? {1'b1, SAT_MIN} : {1'b0, nq};
    end else begin
      r = (q >= Q_HALF) ? {1'b1, SAT_MAX} : {1'b0, q[CW-1:0]};
    end
    return r;
  endfunction

  // Add a quotient to a start coordinate and clip; result is {saturated, value}
  function automatic logic [CW:0] clip_pt(input logic neg, input logic ovf,
                                          input logic [QW-1:0] q,
                                          input logic signed [CW-1:0] base);
    logic signed [QW+1:0] dq;
    logic signed [QW+1:0] sum;
    logic [CW:0]          r;
    dq  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum = (QW + 2)'(base) + dq;
    priority if (ovf) begin
      r = neg ? {1'b1, SAT_MIN} : {1'b1, SAT_MAX};
    end else if (sum > PT_MAX) begin
      r = {1'b1, SAT_MAX};
    end else if (sum < PT_MIN) begin
      r = {1'b1, SAT_MIN};
    end else begin
      r = {1'b0, sum[CW-1:0]};
    end
    return r;
  endfunction

  // Tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TW'(1);
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  // Advance the whole pipeline while the output buffer has room
  assign en            = ~skid_vld;
  assign s_axis_tready = en;

  assign asx = s_axis_tdata[I_ASX +: CW];
  assign asy = s_axis_tdata[I_ASY +: CW];
  assign aex = s_axis_tdata[I_AEX +: CW];
  assign aey = s_axis_tdata[I_AEY +: CW];
  assign bsx = s_axis_tdata[I_BSX +: CW];
  assign bsy = s_axis_tdata[I_BSY +: CW];
  assign bex = s_axis_tdata[I_BEX +: CW];
  assign bey = s_axis_tdata[I_BEY +: CW];

  // Valid bits for the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s_axis_tvalid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  // Stage 1: direction differences and offset of B's start
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m0  <= MW'(bsx) - MW'(bex);
      s1_m1  <= MW'(aex) - MW'(asx);
      s1_m2  <= MW'(bsy) - MW'(bey);
      s1_m3  <= MW'(aey) - MW'(asy);
      s1_wx  <= MW'(bsx) - MW'(asx);
      s1_wy  <= MW'(bsy) - MW'(asy);
      s1_asx <= asx;
      s1_asy <= asy;
    end
  end

  // Stage 2: all cross products
  assign m1_neg = -s1_m1;
  assign m3_neg = -s1_m3;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p03  <= s1_m0 * s1_m3;
      s2_p12  <= s1_m1 * s1_m2;
      s2_p0y  <= s1_m0 * s1_wy;
      s2_px2  <= s1_wx * s1_m2;
      s2_p3x  <= s1_m3 * s1_wx;
      s2_p1y  <= s1_m1 * s1_wy;
      s2_p11  <= s1_m1 * s1_m1;
      s2_p33  <= s1_m3 * s1_m3;
      s2_tol2 <= tolerance * tolerance;
      s2_m1a  <= s1_m1[MW-1] ? m1_neg : s1_m1;
      s2_m3a  <= s1_m3[MW-1] ? m3_neg : s1_m3;
      s2_m1n  <= s1_m1[MW-1];
      s2_m3n  <= s1_m3[MW-1];
      s2_asx  <= s1_asx;
      s2_asy  <= s1_asy;
    end
  end

  // Stage 3: determinant, both numerators, squared length of A
  always_ff @(posedge clk) begin
    if (en) begin
      s3_det  <= SW'(s2_p03) - SW'(s2_p12);
      s3_nt   <= SW'(s2_p0y) - SW'(s2_px2);
      s3_nu   <= SW'(s2_p3x) - SW'(s2_p1y);
      s3_len2 <= $unsigned(s2_p11) + $unsigned(s2_p33);
      s3_tol2 <= s2_tol2;
      s3_m1a  <= s2_m1a;
      s3_m3a  <= s2_m3a;
      s3_m1n  <= s2_m1n;
      s3_m3n  <= s2_m3n;
      s3_asx  <= s2_asx;
      s3_asy  <= s2_asy;
    end
  end

  // Stage 4: magnitudes, signs, tolerance-weighted length in two halves
  assign det_neg = -s3_det;
  assign nt_neg  = -s3_nt;
  assign nu_neg  = -s3_nu;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_dabs  <= s3_det[SW-1] ? det_neg[DW-1:0] : s3_det[DW-1:0];
      s4_ntabs <= s3_nt[SW-1]  ? nt_neg[DW-1:0]  : s3_nt[DW-1:0];
      s4_nuabs <= s3_nu[SW-1]  ? nu_neg[DW-1:0]  : s3_nu[DW-1:0];
      s4_dn    <= s3_det[SW-1];
      s4_ntn   <= s3_nt[SW-1];
      s4_nun   <= s3_nu[SW-1];
      s4_rlo   <= s3_len2[HW-1:0] * s3_tol2;
      s4_rhi   <= s3_len2[DW-1:HW] * s3_tol2;
      s4_m1a   <= s3_m1a;
      s4_m3a   <= s3_m3a;
      s4_m1n   <= s3_m1n;
      s4_m3n   <= s3_m3n;
      s4_asx   <= s3_asx;
      s4_asy   <= s3_asy;
    end
  end

  // Stage 5: colinear test, partial products of the point numerators and of the offset squared
  always_ff @(posedge clk) begin
    if (en) begin
      s5_colin      <= s4_dabs <= DW'({tolerance, 17'b0});
      s5_csmall     <= s4_nuabs[DW-1:CSW] == '0;
      s5_xlo        <= s4_ntabs[HW-1:0] * s4_m1a;
      s5_xhi        <= s4_ntabs[DW-1:HW] * s4_m1a;
      s5_ylo        <= s4_ntabs[HW-1:0] * s4_m3a;
      s5_yhi        <= s4_ntabs[DW-1:HW] * s4_m3a;
      s5_cll        <= s4_nuabs[CLW-1:0] * s4_nuabs[CLW-1:0];
      s5_clh        <= s4_nuabs[CLW-1:0] * s4_nuabs[CSW-1:CLW];
      s5_chh        <= s4_nuabs[CSW-1:CLW] * s4_nuabs[CSW-1:CLW];
      s5_rhs        <= NW'(s4_rlo) + (NW'(s4_rhi) << HW);
      s5_dabs       <= s4_dabs;
      s5_ntabs      <= s4_ntabs;
      s5_nuabs      <= s4_nuabs;
      s5_neg[LN_PA] <= s4_ntn ^ s4_dn;
      s5_neg[LN_PB] <= s4_nun ^ s4_dn;
      s5_neg[LN_CX] <= s4_ntn ^ s4_m1n ^ s4_dn;
      s5_neg[LN_CY] <= s4_ntn ^ s4_m3n ^ s4_dn;
      s5_asx        <= s4_asx;
      s5_asy        <= s4_asy;
    end
  end

  // Stage 6: sum partial products
  always_ff @(posedge clk) begin
    if (en) begin
      s6_nx     <= NW'(s5_xlo) + (NW'(s5_xhi) << HW);
      s6_ny     <= NW'(s5_ylo) + (NW'(s5_yhi) << HW);
      s6_c2     <= NW'(s5_cll) + (NW'(s5_clh) << (CLW + 1)) + (NW'(s5_chh) << (2 * CLW));
      s6_rhs    <= s5_rhs;
      s6_colin  <= s5_colin;
      s6_csmall <= s5_csmall;
      s6_dabs   <= s5_dabs;
      s6_ntabs  <= s5_ntabs;
      s6_nuabs  <= s5_nuabs;
      s6_neg    <= s5_neg;
      s6_asx    <= s5_asx;
      s6_asy    <= s5_asy;
    end
  end

  // Divider entry: overlap decision rides along with the quotients
  assign div_num[LN_PA] = NW'({s6_ntabs, {FB{1'b0}}});
  assign div_num[LN_PB] = NW'({s6_nuabs, {FB{1'b0}}});
  assign div_num[LN_CX] = s6_nx;
  assign div_num[LN_CY] = s6_ny;

  always_comb begin
    div_side       = '0;
    div_side.colin = s6_colin;
    div_side.over  = s6_colin & s6_csmall & (s6_c2 < s6_rhs);
    div_side.neg   = s6_neg;
    div_side.asx   = s6_asx;
    div_side.asy   = s6_asy;
  end

  spi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_vld),
    .in_num   (div_num),
    .in_den   (s6_dabs),
    .in_side  (div_side),
    .out_valid(dv_vld),
    .out_quo  (dv_quo),
    .out_ovf  (dv_ovf),
    .out_side (dv_side)
  );

  // Clip quotients and pack the result
  assign pa_r = clip_par(dv_side.neg[LN_PA], dv_ovf[LN_PA], dv_quo[LN_PA]);
  assign pb_r = clip_par(dv_side.neg[LN_PB], dv_ovf[LN_PB], dv_quo[LN_PB]);
  assign cx_r = clip_pt(dv_side.neg[LN_CX], dv_ovf[LN_CX], dv_quo[LN_CX], dv_side.asx);
  assign cy_r = clip_pt(dv_side.neg[LN_CY], dv_ovf[LN_CY], dv_quo[LN_CY], dv_side.asy);

  always_comb begin
    res_next          = '0;
    res_next[O_COLIN] = dv_side.colin;
    res_next[O_OVER]  = dv_side.over;
    if (!dv_side.colin) begin
      res_next[O_CX +: CW] = cx_r[CW-1:0];
      res_next[O_CY +: CW] = cy_r[CW-1:0];
      res_next[O_PA +: CW] = pa_r[CW-1:0];
      res_next[O_PB +: CW] = pb_r[CW-1:0];
      res_next[O_SAT]      = pa_r[CW] | pb_r[CW] | cx_r[CW] | cy_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (en) begin
      res_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= res_next;
    end
  end

  // Output register with one skid entry behind it
  assign push = en & res_vld;
  assign pop  = out_vld & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (pop) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end
    end else if (pop || !out_vld) begin
      out_vld <= push;
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (pop || !out_vld) begin
      out_data <= res_data;
    end else if (push) begin
      skid_data <= res_data;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_data;

endmodule

>>> rtl/core/spi_check.sv
// Port-level checks for the segment pair intersection block, bound to its top level.
module spi_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [spi_pkg::OUT_W-1:0] m_axis_tdata
);
  import spi_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Colinear results carry no point, parameters or clip flag
  a_colin_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[O_COLIN] |-> m_axis_tdata[O_SAT:O_CX] == '0)
    else $error("colinear result has nonzero point fields");

  // Overlap only on colinear pairs
  a_over_colin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[O_OVER] |-> m_axis_tdata[O_COLIN])
    else $error("overlap flagged on non-colinear pair");

  // Input closes only after a result was refused
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input closed without output stall");

endmodule

bind segment_pair_intersection spi_check u_spi_check (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> tb/sv/tb_segment_pair_intersection.sv
// Self-checking testbench for the segment pair intersection block.
module tb_segment_pair_intersection;
  import spi_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic        saturated;
    logic [31:0] param_b;
    logic [31:0] param_a;
    logic [31:0] cross_y;
    logic [31:0] cross_x;
    logic        overlapped;
    logic        colinear;
  } crossing_t;

  logic                clk = 0;
  logic                rst = 1;
  logic                cfg_wr_en = 0;
  logic [TW-1:0]       cfg_wr_data = '0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;   // asx, asy, aex, aey, bsx, bsy, bex, bey
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OUT_W-1:0]    m_axis_tdata;        // colinear, overlapped, cx, cy, pa, pb, sat, pad

  logic [IN_W-1:0] pending_pairs[$];
  crossing_t       expected_crossings[$];
  logic [TW-1:0]   tol_shadow = TW'(1);
  bit              quiet = 0;
  bit              hold_req = 0;
  bit              failed = 0;
  int              send_gap = 0;
  int              stall_left = 0;
  int              hold_left = 0;
  int              cycles = 0;

  segment_pair_intersection dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Clip a wide value to 32 signed bits, flag when clipped
  function automatic logic [31:0] clip32(input logic signed [191:0] v, inout logic s);
    if (v > 192'sd2147483647) begin
      s = 1;
      return 32'h7fffffff;
    end
    if (v < -192'sd2147483648) begin
      s = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Work out the crossing result of one segment pair at a given tolerance
  function automatic crossing_t predict_crossing(input logic [IN_W-1:0] d,
                                                 input logic [TW-1:0] tol);
    logic signed [191:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
    logic signed [191:0] m0, m1, m2, m3, det, adet, lim, wx, wy, nt, nu, c, len2, t;
    logic                s;
    crossing_t           r;
    asx = $signed(d[31:0]);    asy = $signed(d[63:32]);
    aex = $signed(d[95:64]);   aey = $signed(d[127:96]);
    bsx = $signed(d[159:128]); bsy = $signed(d[191:160]);
    bex = $signed(d[223:192]); bey = $signed(d[255:224]);
    m0 = bsx - bex; m1 = aex - asx; m2 = bsy - bey; m3 = aey - asy;
    det = m0 * m3 - m1 * m2;
    adet = det < 0 ? -det : det;
    t = {176'd0, tol};
    lim = t <<< 17;
    r = '0;
    s = 0;
    if (adet > lim) begin
      wx = bsx - asx; wy = bsy - asy;
      nt = m0 * wy - wx * m2;
      nu = m3 * wx - m1 * wy;
      r.param_a = clip32((nt <<< 16) / det, s);
      r.param_b = clip32((nu <<< 16) / det, s);
      r.cross_x = clip32(asx + (nt * m1) / det, s);
      r.cross_y = clip32(asy + (nt * m3) / det, s);
      r.saturated = s;
    end else begin
      // squared distance test of B start against A's carrier line
      c = m3 * (asx - bsx) - m1 * (asy - bsy);
      len2 = m1 * m1 + m3 * m3;
      r.colinear = 1;
      r.overlapped = (c * c) < (len2 * t * t);
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(int asx, int asy, int aex, int aey,
                                                int bsx, int bsy, int bex, int bey);
    return {bey, bex, bsy, bsx, aey, aex, asy, asx};
  endfunction

  // Random pair: wide noise, small-range crossings, or segments along one line
  function automatic logic [IN_W-1:0] random_pair();
    int dx, dy, ax, ay, ka, kb, kj, ex, ey;
    ax = $signed($urandom_range(0, 32'h01ffffff)) - 32'h01000000;
    ay = $signed($urandom_range(0, 32'h01ffffff)) - 32'h01000000;
    case ($urandom_range(0, 9))
      0, 1: return {$urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom()};
      2, 3, 4: return pack_pair(ax, ay,
                    ax + $signed($urandom_range(0, 32'h3fffff)) - 32'h200000,
                    ay + $signed($urandom_range(0, 32'h3fffff)) - 32'h200000,
                    ax + $signed($urandom_range(0, 32'h3fffff)) - 32'h200000,
                    ay + $signed($urandom_range(0, 32'h3fffff)) - 32'h200000,
                    ax + $signed($urandom_range(0, 32'h3fffff)) - 32'h200000,
                    ay + $signed($urandom_range(0, 32'h3fffff)) - 32'h200000);
      default: begin
        dx = $signed($urandom_range(0, 8191)) - 4096;
        dy = $signed($urandom_range(0, 8191)) - 4096;
        ka = $signed($urandom_range(0, 255)) - 128;
        kb = $signed($urandom_range(0, 255)) - 128;
        kj = $signed($urandom_range(0, 255)) - 128;
        ex = $signed($urandom_range(0, 6)) - 3;
        ey = $signed($urandom_range(0, 6)) - 3;
        // nudge B's end now and then to land near the colinear limit
        return pack_pair(ax, ay, ax + ka * dx, ay + ka * dy,
                         ax + kb * dx + ex, ay + kb * dy + ey,
                         ax + kb * dx + ex + kj * dx + ($urandom_range(0, 3) == 0 ? ex : 0),
                         ay + kb * dy + ey + kj * dy);
      end
    endcase
  endfunction

  // Offer pending items, idle in random bursts, record expectations on accept
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_crossings.insert(expected_crossings.size(),
                                  predict_crossing(pending_pairs.pop_front(), tol_shadow));
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 0;
      end else if (pending_pairs.size() == 0) begin
        s_axis_tvalid <= 0;
      end else if (!quiet && (!s_axis_tvalid || s_axis_tready) &&
                   $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        s_axis_tvalid <= 0;
      end else begin
        s_axis_tvalid <= 1;
        s_axis_tdata <= pending_pairs[0];
      end
    end
  end

  // Check each result item against the oldest expectation, stall at random
  always @(posedge clk) begin
    crossing_t got, want;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[O_SAT:0];
        if (expected_crossings.size() == 0) begin
          $error("unexpected result item %h", got);
          failed = 1;
        end else begin
          want = expected_crossings.pop_front();
          if (got.colinear !== want.colinear) begin
            $error("colinear exp %0d got %0d", want.colinear, got.colinear); failed = 1;
          end
          if (got.overlapped !== want.overlapped) begin
            $error("overlapped exp %0d got %0d", want.overlapped, got.overlapped); failed = 1;
          end
          if (got.cross_x !== want.cross_x) begin
            $error("cross_x exp %h got %h", want.cross_x, got.cross_x); failed = 1;
          end
          if (got.cross_y !== want.cross_y) begin
            $error("cross_y exp %h got %h", want.cross_y, got.cross_y); failed = 1;
          end
          if (got.param_a !== want.param_a) begin
            $error("param_a exp %h got %h", want.param_a, got.param_a); failed = 1;
          end
          if (got.param_b !== want.param_b) begin
            $error("param_b exp %h got %h", want.param_b, got.param_b); failed = 1;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated exp %0d got %0d", want.saturated, got.saturated); failed = 1;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
        m_axis_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_tolerance(input logic [TW-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    tol_shadow = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // Append one item to the send queue
  task automatic queue_pair(input logic [IN_W-1:0] p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && expected_crossings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    repeat (n) queue_pair(random_pair());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed items at reset tolerance
    queue_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));                 // A degenerate
    queue_pair(pack_pair(5, 7, 5, 7, 1 << 16, 0, 0, 1 << 16));     // A a point
    queue_pair(pack_pair(0, 0, 1 << 16, 0, 0, -1 << 16, 0, 1 << 16)); // cross
    queue_pair(pack_pair(-1 << 16, -1 << 16, 1 << 16, 1 << 16,
                         -1 << 16, 1 << 16, 1 << 16, -1 << 16));
    queue_pair(pack_pair(0, 0, 4 << 16, 0, 1 << 16, 0, 3 << 16, 0)); // overlap
    queue_pair(pack_pair(0, 0, 4 << 16, 0, 1 << 16, 9, 3 << 16, 9)); // parallel
    queue_pair(pack_pair(0, 0, 4 << 16, 0, 1 << 16, 1, 3 << 16, 1));
    queue_pair(pack_pair(0, 0, 2, 0, 0, 0, 0, 1));                 // |D| below limit
    queue_pair(pack_pair(0, 0, 3, 0, 0, 0, 0, 1));
    queue_pair(pack_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    queue_pair(pack_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                         32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000));
    queue_pair(pack_pair(0, 0, 32'h7fffffff, 1, 0, 3, 32'h7fffffff, 0)); // clip
    queue_pair(pack_pair(0, 0, 1, 0, 32'h7fff0000, -5, 32'h7fff0000, 5));
    queue_pair(pack_pair(32'h80000000, 0, 32'h80000001, 0,
                         32'h7fffffff, -1, 32'h7fffffff, 1));
    queue_pair(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    queue_pair(pack_pair(1, 2, 3, 4, 5, 6, 7, 9));
    drain();

    // Random phases over several tolerance settings
    random_phase(200);
    write_tolerance(0);
    queue_pair(pack_pair(0, 0, 4 << 16, 0, 1 << 16, 0, 3 << 16, 0));
    random_phase(200);
    write_tolerance(16'hffff);
    queue_pair(pack_pair(0, 0, 4 << 16, 0, 1 << 16, 1, 3 << 16, 1));
    hold_req = 1;
    random_phase(250);
    write_tolerance(TW'($urandom_range(2, 300)));
    random_phase(250);
    write_tolerance(1);
    quiet = 1;
    random_phase(250);

    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
